FILE: rtl/rlg_pkg.sv
// Shared types and constants of the LFSR/LCG random generator with range mapping.
`default_nettype none

package rlg_pkg;

    localparam int OUT_WIDTH_DEF = 32;
    localparam int WORD_W        = 32;
    localparam int SEED_W        = 64;
    localparam int CNT_W         = 6;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 6;
    localparam int Q_DEPTH       = 2;

    localparam logic [SEED_W-1:0] SEED_RESET = 64'h0000_0000_0000_ACE1;
    localparam logic [30:0]       LCG_MUL    = 31'd1103515245;
    localparam logic [SEED_W-1:0] LCG_ADD    = 64'd12345;
    localparam logic [WORD_W-1:0] SIGN_BIAS  = 32'h8000_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_GEN_MODE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_COUNT = 1'd1;

    localparam logic OP_RAW    = 1'b0;
    localparam logic OP_RANGED = 1'b1;

    localparam logic MODE_LFSR = 1'b0;
    localparam logic MODE_LCG  = 1'b1;

    typedef struct packed {
        logic                     op;
        logic signed [WORD_W-1:0] range_min;
        logic signed [WORD_W-1:0] range_max;
    } t_in_word;

    typedef struct packed {
        logic        [WORD_W-1:0] raw_value;
        logic signed [WORD_W-1:0] ranged_value;
        logic                     range_error;
    } t_out_word;

    typedef struct packed {
        logic [WORD_W-1:0] raw_value;
        logic [WORD_W-1:0] range_min;
        logic [WORD_W-1:0] span;
        logic              op;
        logic              err;
        logic              need_div;
    } t_job;

endpackage

`default_nettype wire

FILE: rtl/rlg_front.sv
// Front end: configuration registers, seed generator and range classification.
`default_nettype none

module rlg_front #(
    parameter int OUT_WIDTH = rlg_pkg::OUT_WIDTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             push,
    output logic                                  full,
    input  wire rlg_pkg::t_in_word                i_in_word,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [rlg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [rlg_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                                  o_job_valid,
    input  wire logic                             i_job_ready,
    output rlg_pkg::t_job                         o_job
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LFSR = 3'd1;
    localparam logic [2:0] S_MLO  = 3'd2;
    localparam logic [2:0] S_MHI  = 3'd3;
    localparam logic [2:0] S_ADD  = 3'd4;
    localparam logic [2:0] S_PUSH = 3'd5;

    logic [2:0]                        r_state;
    logic [rlg_pkg::SEED_W-1:0]        r_seed;
    logic [OUT_WIDTH-1:0]              r_value;
    logic [rlg_pkg::CNT_W-1:0]         r_cnt;
    logic [rlg_pkg::SEED_W-1:0]        r_prod;
    logic [rlg_pkg::WORD_W-1:0]        r_phi;
    logic                              r_op;
    logic                              r_err;
    logic [rlg_pkg::WORD_W-1:0]        r_min;
    logic [rlg_pkg::WORD_W-1:0]        r_span;
    logic                              r_gen_mode;
    logic [rlg_pkg::CNT_W-1:0]         r_bit_count;

    logic                              w_accept;
    logic [rlg_pkg::CNT_W-1:0]         w_count;
    logic [rlg_pkg::WORD_W-1:0]        w_lo;
    logic [rlg_pkg::WORD_W-1:0]        w_hi;
    logic [rlg_pkg::WORD_W-1:0]        w_diff;
    logic                              w_err;
    logic [rlg_pkg::WORD_W-1:0]        w_mul_a;
    logic [62:0]                       w_mul;
    logic                              w_fb;
    logic [OUT_WIDTH:0]                w_val_shift;
    logic [rlg_pkg::SEED_W-1:0]        w_lcg;
    logic [rlg_pkg::WORD_W-1:0]        w_lcg_draw;

    assign w_accept  = push && !full;
    assign full      = (r_state != S_IDLE);
    assign cfg_ready = 1'b1;

    assign w_count = (r_bit_count > rlg_pkg::CNT_W'(OUT_WIDTH))
                   ? rlg_pkg::CNT_W'(OUT_WIDTH) : r_bit_count;

    assign w_lo   = i_in_word.range_min ^ rlg_pkg::SIGN_BIAS;
    assign w_hi   = i_in_word.range_max ^ rlg_pkg::SIGN_BIAS;
    assign w_diff = w_hi - w_lo;
    assign w_err  = (i_in_word.op == rlg_pkg::OP_RANGED) && ((w_lo > w_hi) || w_diff[31]);

    assign w_mul_a = (r_state == S_MLO) ? r_seed[31:0] : r_seed[63:32];
    assign w_mul   = {31'd0, w_mul_a} * {32'd0, rlg_pkg::LCG_MUL};

    assign w_fb        = r_seed[0] ^ r_seed[59] ^ r_seed[60] ^ r_seed[62] ^ r_seed[63];
    assign w_val_shift = {r_value, r_seed[0]};

    assign w_lcg      = r_prod + {r_phi, 32'd0} + rlg_pkg::LCG_ADD;
    assign w_lcg_draw = {17'd0, w_lcg[30:16]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seed      <= rlg_pkg::SEED_RESET;
            r_gen_mode  <= rlg_pkg::MODE_LFSR;
            r_bit_count <= rlg_pkg::CNT_W'(32);
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (i_cfg_index)
                    rlg_pkg::CFG_GEN_MODE:  r_gen_mode  <= i_cfg_data[0];
                    rlg_pkg::CFG_BIT_COUNT: r_bit_count <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_seed <= (r_seed == '0) ? rlg_pkg::SEED_W'(1) : r_seed;
                        if (r_gen_mode == rlg_pkg::MODE_LCG) begin
                            r_state <= S_MLO;
                        end else if (w_count == '0) begin
                            r_state <= S_PUSH;
                        end else begin
                            r_state <= S_LFSR;
                        end
                    end
                end
                S_LFSR: begin
                    r_seed <= {w_fb, r_seed[63:1]};
                    if (r_cnt == rlg_pkg::CNT_W'(1)) begin
                        r_state <= S_PUSH;
                    end
                end
                S_MLO:   r_state <= S_MHI;
                S_MHI:   r_state <= S_ADD;
                S_ADD: begin
                    r_seed  <= w_lcg;
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (i_job_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_value <= '0;
                r_cnt   <= w_count;
                r_op    <= i_in_word.op;
                r_err   <= w_err;
                r_min   <= i_in_word.range_min;
                r_span  <= w_diff + rlg_pkg::WORD_W'(1);
            end
            S_LFSR: begin
                r_value <= w_val_shift[OUT_WIDTH-1:0];
                r_cnt   <= r_cnt - rlg_pkg::CNT_W'(1);
            end
            S_MLO:   r_prod  <= 64'(w_mul);
            S_MHI:   r_phi   <= w_mul[31:0];
            S_ADD:   r_value <= w_lcg_draw[OUT_WIDTH-1:0];
            default: ;
        endcase
    end

    assign o_job_valid      = (r_state == S_PUSH);
    assign o_job.raw_value  = rlg_pkg::WORD_W'(r_value);
    assign o_job.range_min  = r_min;
    assign o_job.span       = r_span;
    assign o_job.op         = r_op;
    assign o_job.err        = r_err;
    assign o_job.need_div   = (r_op == rlg_pkg::OP_RANGED) && !r_err;

endmodule

`default_nettype wire

FILE: rtl/rlg_queue.sv
// Short job queue between the generator front end and the range back end.
`default_nettype none

module rlg_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr,
    input  wire rlg_pkg::t_job i_wdata,
    output logic               o_full,
    input  wire logic          i_rd,
    output rlg_pkg::t_job      o_rdata,
    output logic               o_empty
);

    localparam int PTR_W = $clog2(rlg_pkg::Q_DEPTH);
    localparam int CNT_W = $clog2(rlg_pkg::Q_DEPTH + 1);

    rlg_pkg::t_job     r_mem [rlg_pkg::Q_DEPTH];
    logic [PTR_W-1:0]  r_wptr;
    logic [PTR_W-1:0]  r_rptr;
    logic [CNT_W-1:0]  r_count;
    logic              w_wr;
    logic              w_rd;

    assign o_full  = (r_count == CNT_W'(rlg_pkg::Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= (r_wptr == PTR_W'(rlg_pkg::Q_DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            end
            if (w_rd) begin
                r_rptr <= (r_rptr == PTR_W'(rlg_pkg::Q_DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rlg_back.sv
// Back end: bit-serial modulo by the range span and the result register.
`default_nettype none

module rlg_back #(
    parameter int OUT_WIDTH = rlg_pkg::OUT_WIDTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_empty,
    input  wire rlg_pkg::t_job i_job,
    output logic               o_rd,
    output logic               empty,
    input  wire logic          pop,
    output rlg_pkg::t_out_word o_out_word
);

    localparam int STEP_W = $clog2(OUT_WIDTH + 1);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_DIV  = 2'd1;
    localparam logic [1:0] B_OUT  = 2'd2;

    logic [1:0]                  r_state;
    logic                        r_out_valid;
    rlg_pkg::t_job               r_job;
    logic [rlg_pkg::WORD_W-1:0]  r_rem;
    logic [OUT_WIDTH-1:0]        r_dvd;
    logic [STEP_W-1:0]           r_step;
    rlg_pkg::t_out_word          r_out;

    logic [rlg_pkg::WORD_W:0]    w_trial;
    logic [rlg_pkg::WORD_W:0]    w_sub;
    logic                        w_ge;
    logic                        w_free;
    logic [rlg_pkg::WORD_W-1:0]  w_ranged;

    assign o_rd    = (r_state == B_IDLE) && !i_q_empty;
    assign w_trial = {r_rem, r_dvd[OUT_WIDTH-1]};
    assign w_sub   = w_trial - {1'b0, r_job.span};
    assign w_ge    = (w_trial >= {1'b0, r_job.span});
    assign w_free  = !r_out_valid || pop;

    always_comb begin
        if (r_job.op == rlg_pkg::OP_RAW) begin
            w_ranged = '0;
        end else if (r_job.err) begin
            w_ranged = r_job.range_min;
        end else begin
            w_ranged = r_rem + r_job.range_min;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                B_IDLE: begin
                    if (!i_q_empty) begin
                        r_state <= i_job.need_div ? B_DIV : B_OUT;
                    end
                end
                B_DIV: begin
                    if (r_step == STEP_W'(1)) begin
                        r_state <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (w_free) begin
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
            if ((r_state == B_OUT) && w_free) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_job  <= i_job;
                r_rem  <= '0;
                r_dvd  <= i_job.raw_value[OUT_WIDTH-1:0];
                r_step <= STEP_W'(OUT_WIDTH);
            end
            B_DIV: begin
                r_rem  <= w_ge ? w_sub[rlg_pkg::WORD_W-1:0] : w_trial[rlg_pkg::WORD_W-1:0];
                r_dvd  <= r_dvd << 1;
                r_step <= r_step - STEP_W'(1);
            end
            B_OUT: begin
                if (w_free) begin
                    r_out.raw_value    <= r_job.raw_value;
                    r_out.ranged_value <= w_ranged;
                    r_out.range_error  <= r_job.err;
                end
            end
            default: ;
        endcase
    end

    assign empty      = !r_out_valid;
    assign o_out_word = r_out;

endmodule

`default_nettype wire

FILE: rtl/lfsr_lcg_random_with_range.sv
// Random generator with range mapping: LFSR/LCG seed front end, queue, modulo back end.
// Input side is a queue write port: a request word {op, range_min, range_max} is taken
// at a clock edge with push high and full low. Result side is a queue read port: while
// empty is low the oldest result {raw_value, ranged_value, range_error} is on
// o_out_word and is taken at an edge with pop high. Registers gen_mode (index 0) and
// bit_count (index 1) are written over cfg_valid/cfg_ready, which is always ready.
// The front end draws one value per request: min(bit_count, OUT_WIDTH) bits in
// LFSR mode (one shift a cycle) or, in LCG mode, from two 32x31 partial products
// and a sum, then hands a job to a two-entry queue. The back end computes raw mod span
// one bit a cycle for a valid ranged request and passes other requests straight on.
// Sustained throughput is set by the slower of the two parts. Reset loads seed 0xACE1,
// gen_mode 0 and bit_count 32 and empties queue and result register. When the
// receiver stalls the result holds, the back end then the queue fill, and full rises.
`default_nettype none

module lfsr_lcg_random_with_range #(
    parameter int OUT_WIDTH = rlg_pkg::OUT_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire rlg_pkg::t_in_word               i_in_word,
    output logic                                 empty,
    input  wire logic                            pop,
    output rlg_pkg::t_out_word                   o_out_word,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [rlg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [rlg_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic          w_job_valid;
    logic          w_q_full;
    rlg_pkg::t_job w_job_in;
    rlg_pkg::t_job w_job_out;
    logic          w_q_empty;
    logic          w_q_rd;

    rlg_front #(
        .OUT_WIDTH(OUT_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_word   (i_in_word),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_job_valid (w_job_valid),
        .i_job_ready (!w_q_full),
        .o_job       (w_job_in)
    );

    rlg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_job_valid),
        .i_wdata (w_job_in),
        .o_full  (w_q_full),
        .i_rd    (w_q_rd),
        .o_rdata (w_job_out),
        .o_empty (w_q_empty)
    );

    rlg_back #(
        .OUT_WIDTH(OUT_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (w_q_empty),
        .i_job      (w_job_out),
        .o_rd       (w_q_rd),
        .empty      (empty),
        .pop        (pop),
        .o_out_word (o_out_word)
    );

endmodule

`default_nettype wire

FILE: sim/tb_lfsr_lcg_random_with_range.sv
// Testbench for lfsr_lcg_random_with_range: directed and random requests against a predictor.
`timescale 1ns / 100ps

module tb_lfsr_lcg_random_with_range;

    localparam int LONG_HOLD   = 150;
    localparam int DRAIN_TAIL  = 80;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_WORDS = 50;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           push;
    logic                           full;
    rlg_pkg::t_in_word              i_in_word;
    logic                           empty;
    logic                           pop;
    rlg_pkg::t_out_word             o_out_word;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [rlg_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [rlg_pkg::CFG_DATA_W-1:0] i_cfg_data;

    logic [rlg_pkg::SEED_W-1:0]     seed_q;
    logic                           mode_q;
    logic [rlg_pkg::CNT_W-1:0]      count_q;
    rlg_pkg::t_out_word             result_q[$];
    int                             mismatch_count = 0;
    logic                           src_idle_on = 1'b1;
    logic                           pop_idle_on = 1'b1;
    int                             hold_asks = 0;
    int                             hold_seen = 0;

    lfsr_lcg_random_with_range i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_word   (i_in_word),
        .empty       (empty),
        .pop         (pop),
        .o_out_word  (o_out_word),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [rlg_pkg::WORD_W-1:0] next_draw();
        logic [rlg_pkg::WORD_W-1:0] value;
        int                         n;
        logic                       fb;
        value = '0;
        if (seed_q == '0) seed_q = 64'd1;
        if (mode_q == rlg_pkg::MODE_LFSR) begin
            n = (count_q > 6'd32) ? 32 : int'(count_q);
            for (int k = n; k > 0; k--) begin
                value[k-1] = seed_q[0];
                fb = seed_q[0] ^ seed_q[59] ^ seed_q[60] ^ seed_q[62] ^ seed_q[63];
                seed_q = {fb, seed_q[63:1]};
            end
        end else begin
            seed_q = seed_q * {33'b0, rlg_pkg::LCG_MUL} + rlg_pkg::LCG_ADD;
            value = {17'b0, seed_q[30:16]};
        end
        return value;
    endfunction

    function automatic rlg_pkg::t_out_word expected_result(rlg_pkg::t_in_word w);
        rlg_pkg::t_out_word r;
        logic [63:0]        lo;
        logic [63:0]        hi;
        logic [63:0]        span;
        logic [63:0]        rem;
        r.raw_value    = next_draw();
        r.ranged_value = '0;
        r.range_error  = 1'b0;
        if (w.op == rlg_pkg::OP_RANGED) begin
            lo   = {32'b0, w.range_min ^ rlg_pkg::SIGN_BIAS};
            hi   = {32'b0, w.range_max ^ rlg_pkg::SIGN_BIAS};
            span = hi - lo + 64'd1;
            if (lo > hi || span > 64'h8000_0000) begin
                r.range_error  = 1'b1;
                r.ranged_value = w.range_min;
            end else begin
                rem = {32'b0, r.raw_value} % span;
                r.ranged_value = rem[31:0] + w.range_min;
            end
        end
        return r;
    endfunction

    function automatic rlg_pkg::t_in_word req(logic op, logic [31:0] lo, logic [31:0] hi);
        rlg_pkg::t_in_word w;
        w.op        = op;
        w.range_min = lo;
        w.range_max = hi;
        return w;
    endfunction

    function automatic rlg_pkg::t_in_word rand_request();
        logic [31:0] lo;
        logic [31:0] hi;
        lo = $urandom;
        case ($urandom_range(0, 4))
            0:       hi = $urandom;
            1:       hi = lo + $urandom_range(0, 15);
            2:       hi = lo + $urandom_range(0, 100000);
            3:       hi = lo + 32'h7FFF_FFFF + $urandom_range(0, 1);
            default: hi = lo;
        endcase
        return req(($urandom_range(0, 3) != 0) ? rlg_pkg::OP_RANGED : rlg_pkg::OP_RAW,
                   lo, hi);
    endfunction

    task automatic send_word(input rlg_pkg::t_in_word w);
        if (src_idle_on && $urandom_range(0, 5) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_word <= w;
        push      <= 1'b1;
        do @(posedge i_clk); while (full);
        result_q.push_back(expected_result(w));
    endtask

    task automatic drain_results();
        push <= 1'b0;
        do @(posedge i_clk); while (result_q.size() != 0);
    endtask

    task automatic set_config(input logic mode, input logic [rlg_pkg::CNT_W-1:0] count);
        cfg_valid   <= 1'b1;
        i_cfg_index <= rlg_pkg::CFG_GEN_MODE;
        i_cfg_data  <= {{(rlg_pkg::CFG_DATA_W-1){1'b0}}, mode};
        do @(posedge i_clk); while (!cfg_ready);
        mode_q = mode;
        i_cfg_index <= rlg_pkg::CFG_BIT_COUNT;
        i_cfg_data  <= count;
        do @(posedge i_clk); while (!cfg_ready);
        count_q = count;
        cfg_valid <= 1'b0;
    endtask

    task automatic test_range_edges();
        send_word(req(rlg_pkg::OP_RAW, 32'h1234_5678, 32'h0000_0001));
        send_word(req(rlg_pkg::OP_RANGED, 32'd7, 32'd7));
        send_word(req(rlg_pkg::OP_RANGED, 32'h8000_0000, 32'hFFFF_FFFF));
        send_word(req(rlg_pkg::OP_RANGED, 32'h8000_0000, 32'h0000_0000));
        send_word(req(rlg_pkg::OP_RANGED, 32'd10, 32'hFFFF_FFF6));
        send_word(req(rlg_pkg::OP_RANGED, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_word(req(rlg_pkg::OP_RANGED, 32'h8000_0000, 32'h8000_0000));
        send_word(req(rlg_pkg::OP_RANGED, 32'h0000_0000, 32'h7FFF_FFFF));
        send_word(req(rlg_pkg::OP_RANGED, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
        send_word(req(rlg_pkg::OP_RANGED, 32'hFFFF_FFFB, 32'd5));
        drain_results();
    endtask

    task automatic test_bit_counts();
        logic [rlg_pkg::CNT_W-1:0] counts[5] = '{6'd0, 6'd1, 6'd33, 6'd63, 6'd17};
        foreach (counts[i]) begin
            set_config(rlg_pkg::MODE_LFSR, counts[i]);
            send_word(req(rlg_pkg::OP_RAW, 32'h0, 32'h0));
            send_word(req(rlg_pkg::OP_RANGED, 32'hFFFF_FF00, 32'h0000_00FF));
            drain_results();
        end
    endtask

    task automatic test_lcg_mode();
        set_config(rlg_pkg::MODE_LCG, 6'd63);
        send_word(req(rlg_pkg::OP_RAW, 32'hFFFF_FFFF, 32'h8000_0000));
        send_word(req(rlg_pkg::OP_RANGED, 32'd100, 32'd1099));
        send_word(req(rlg_pkg::OP_RANGED, 32'd3, 32'd2));
        send_word(req(rlg_pkg::OP_RANGED, 32'h8000_0000, 32'hFFFF_FFFF));
        drain_results();
    endtask

    task automatic test_backpressure();
        set_config(rlg_pkg::MODE_LFSR, 6'd4);
        src_idle_on = 1'b0;
        hold_asks++;
        repeat (20) send_word(rand_request());
        drain_results();
        src_idle_on = 1'b1;
    endtask

    task automatic test_random();
        logic                      mode;
        logic [rlg_pkg::CNT_W-1:0] count;
        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p == RAND_PHASES - 1) begin
                src_idle_on = 1'b0;
                pop_idle_on = 1'b0;
            end
            mode = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 5))
                0:       count = 6'd0;
                1:       count = 6'd32;
                2:       count = 6'd63;
                3:       count = 6'd1;
                default: count = rlg_pkg::CNT_W'($urandom_range(0, 63));
            endcase
            set_config(mode, count);
            repeat (PHASE_WORDS) send_word(rand_request());
            drain_results();
        end
    endtask

    initial begin : sink
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                pop <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                pop <= 1'b1;
            end else if (pop_idle_on && $urandom_range(0, 6) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                pop <= 1'b1;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        rlg_pkg::t_out_word want;
        if (i_rst_n && pop && !empty) begin
            if (result_q.size() == 0) begin
                $error("unexpected result word: raw_value %h", o_out_word.raw_value);
                mismatch_count++;
            end else begin
                want = result_q.pop_front();
                if (o_out_word.raw_value !== want.raw_value) begin
                    $error("raw_value: expected %h, got %h",
                           want.raw_value, o_out_word.raw_value);
                    mismatch_count++;
                end
                if (o_out_word.ranged_value !== want.ranged_value) begin
                    $error("ranged_value: expected %0d, got %0d",
                           want.ranged_value, o_out_word.ranged_value);
                    mismatch_count++;
                end
                if (o_out_word.range_error !== want.range_error) begin
                    $error("range_error: expected %b, got %b",
                           want.range_error, o_out_word.range_error);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        i_rst_n     <= 1'b0;
        push        <= 1'b0;
        i_in_word   <= '0;
        cfg_valid   <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        seed_q  = rlg_pkg::SEED_RESET;
        mode_q  = rlg_pkg::MODE_LFSR;
        count_q = 6'd32;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_range_edges();
        test_bit_counts();
        test_lcg_mode();
        test_backpressure();
        test_random();

        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (mismatch_count == 0 && result_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
